// ===== sv/bucketed_histogram_percentile_macros.svh =====
// Assertion macros shared by the histogram block.
// Depends on nothing; included by bhp_ctrl, which checks its own logic.
`ifndef BUCKETED_HISTOGRAM_PERCENTILE_MACROS_SVH
`define BUCKETED_HISTOGRAM_PERCENTILE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BHP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BHP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/bhp_pkg.sv =====
// Package of the bucketed histogram: widths, command and operation codes,
// request, response and status types. Depends on nothing.
`timescale 1ns / 1ps
package bhp_pkg;

   localparam int NBUCKETS = 16;
   localparam int IDX_W    = $clog2(NBUCKETS);
   localparam int VAL_W    = 64;
   localparam int PM_W     = 17;
   localparam int PROD_W   = VAL_W + PM_W;
   localparam logic [PM_W-1:0] PCT_SCALE = 17'd100000;

   localparam logic [1:0] CMD_ADD   = 2'd0;
   localparam logic [1:0] CMD_WRITE = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;
   localparam logic [1:0] CMD_QUERY = 2'd3;

   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NONE     = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD     = 5'd1;
   localparam logic [OP_W-1:0] OP_FIND_RD  = 5'd2;
   localparam logic [OP_W-1:0] OP_FIND     = 5'd3;
   localparam logic [OP_W-1:0] OP_ADD_RD   = 5'd4;
   localparam logic [OP_W-1:0] OP_ADD_WR   = 5'd5;
   localparam logic [OP_W-1:0] OP_SUM_RD   = 5'd6;
   localparam logic [OP_W-1:0] OP_SUM      = 5'd7;
   localparam logic [OP_W-1:0] OP_AVG_GO   = 5'd8;
   localparam logic [OP_W-1:0] OP_AVG_WAIT = 5'd9;
   localparam logic [OP_W-1:0] OP_TGT      = 5'd10;
   localparam logic [OP_W-1:0] OP_TGT_LD   = 5'd11;
   localparam logic [OP_W-1:0] OP_PW_RD    = 5'd12;
   localparam logic [OP_W-1:0] OP_PW_ACC   = 5'd13;
   localparam logic [OP_W-1:0] OP_PW_MUL   = 5'd14;
   localparam logic [OP_W-1:0] OP_PW_CMP   = 5'd15;
   localparam logic [OP_W-1:0] OP_PMAX     = 5'd16;
   localparam logic [OP_W-1:0] OP_PL_RD    = 5'd17;
   localparam logic [OP_W-1:0] OP_PR_RD    = 5'd18;
   localparam logic [OP_W-1:0] OP_PM_SC    = 5'd19;
   localparam logic [OP_W-1:0] OP_PNUM     = 5'd20;
   localparam logic [OP_W-1:0] OP_PDEN     = 5'd21;
   localparam logic [OP_W-1:0] OP_PDIV_GO  = 5'd22;
   localparam logic [OP_W-1:0] OP_PFIN     = 5'd23;
   localparam logic [OP_W-1:0] OP_OUT      = 5'd24;

   typedef struct packed {
      logic [1:0]       command;
      logic [VAL_W-1:0] sample_value;
      logic [3:0]       bucket_index;
      logic [PM_W-1:0]  percentile_milli;
   } req_type;

   typedef struct packed {
      logic [VAL_W-1:0] event_count;
      logic [VAL_W-1:0] average_value;
      logic [VAL_W-1:0] max_value;
      logic [VAL_W-1:0] percentile_value;
   } rsp_type;

   typedef struct packed {
      logic find_hit;
      logic sum_last;
      logic count_zero;
      logic bkt_zero;
      logic pct_hit;
      logic pct_last;
      logic c_zero;
      logic div_done;
   } dp_status_type;

endpackage

// ===== sv/bhp_div.sv =====
// Bit-serial scaled divider: quot = floor(d * num / den) for num <= den.
// Depends on bhp_pkg. One bit of d per cycle.
`timescale 1ns / 1ps
module bhp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [bhp_pkg::VAL_W-1:0]  d,
   input  logic [bhp_pkg::PROD_W-1:0] num,
   input  logic [bhp_pkg::PROD_W-1:0] den,
   output logic                       done,
   output logic [bhp_pkg::VAL_W-1:0]  quot,
   output logic                       inexact
);
   import bhp_pkg::*;

   localparam int CNT_W = $clog2(VAL_W);
   localparam int T_W   = PROD_W + 2;

   logic              busy_ff;
   logic              done_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [VAL_W-1:0]  dsh_ff;
   logic [VAL_W-1:0]  q_ff;
   logic [PROD_W-1:0] num_ff;
   logic [PROD_W-1:0] den_ff;
   logic [T_W-1:0]    t_sh;
   logic [T_W-1:0]    t_rem;
   logic [T_W-1:0]    den1;
   logic [T_W-1:0]    den2;
   logic [1:0]        k;

   always_comb begin
      den1  = T_W'(den_ff);
      den2  = T_W'({den_ff, 1'b0});
      t_sh  = T_W'({acc_ff, 1'b0}) + (dsh_ff[VAL_W-1] ? T_W'(num_ff) : '0);
      if (t_sh >= den2) begin
         t_rem = t_sh - den2;
         k     = 2'd2;
      end else if (t_sh >= den1) begin
         t_rem = t_sh - den1;
         k     = 2'd1;
      end else begin
         t_rem = t_sh;
         k     = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VAL_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         acc_ff <= '0;
         dsh_ff <= d;
         q_ff   <= '0;
         num_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         acc_ff <= t_rem[PROD_W-1:0];
         dsh_ff <= {dsh_ff[VAL_W-2:0], 1'b0};
         q_ff   <= {q_ff[VAL_W-2:0], 1'b0} + VAL_W'(k);
      end
   end

   assign done    = done_ff;
   assign quot    = q_ff;
   assign inexact = (acc_ff != '0);

endmodule

// ===== sv/bhp_dp.sv =====
// Datapath of the histogram: bound and count memories, sum and maximum,
// multiplier, result register. Depends on bhp_pkg and bhp_div.
`timescale 1ns / 1ps
module bhp_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [bhp_pkg::OP_W-1:0]     op,
   input  bhp_pkg::req_type             req_data,
   output bhp_pkg::rsp_type             rsp_data,
   output bhp_pkg::dp_status_type       status
);
   import bhp_pkg::*;

   logic [VAL_W-1:0]  bnd_mem [NBUCKETS];
   logic [VAL_W-1:0]  cnt_mem [NBUCKETS];
   logic [NBUCKETS-1:0] cnt_valid_ff;
   logic [VAL_W-1:0]  bnd_rd_ff;
   logic [VAL_W-1:0]  cnt_rd_ff;
   logic [IDX_W-1:0]  bnd_addr;
   logic [IDX_W-1:0]  cnt_addr;
   logic [VAL_W-1:0]  sum_ff;
   logic [VAL_W-1:0]  max_ff;
   logic [VAL_W-1:0]  key_ff;
   logic [PM_W-1:0]   pm_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic [IDX_W-1:0]  bkt_ff;
   logic [VAL_W-1:0]  count_ff;
   logic [VAL_W-1:0]  avg_ff;
   logic [PROD_W-1:0] target_ff;
   logic [VAL_W-1:0]  s_ff;
   logic [VAL_W-1:0]  c_ff;
   logic [VAL_W-1:0]  left_ff;
   logic [VAL_W-1:0]  right_ff;
   logic [PROD_W-1:0] num_ff;
   logic [PROD_W-1:0] den_ff;
   logic [PROD_W-1:0] prod_ff;
   logic [VAL_W-1:0]  pct_ff;
   rsp_type           rsp_ff;
   logic [VAL_W-1:0]  mul_a;
   logic [PM_W-1:0]   mul_b;
   logic              find_hit;
   logic              div_start;
   logic              div_done;
   logic [VAL_W-1:0]  div_d;
   logic [PROD_W-1:0] div_num;
   logic [PROD_W-1:0] div_den;
   logic [VAL_W-1:0]  div_q;
   logic              div_inexact;
   logic              right_ge;
   logic [VAL_W-1:0]  interp;

   assign find_hit = (key_ff <= bnd_rd_ff) || (idx_ff == IDX_W'(NBUCKETS - 1));
   assign right_ge = (right_ff >= left_ff);

   always_comb begin
      if (c_ff == '0) begin
         interp = left_ff;
      end else if (right_ge) begin
         interp = left_ff + div_q;
      end else begin
         interp = left_ff - div_q - VAL_W'(div_inexact);
      end
   end

   always_comb begin
      bnd_addr = idx_ff;
      cnt_addr = idx_ff;
      mul_a    = '0;
      mul_b    = '0;
      unique case (op)
         OP_FIND:   bnd_addr = idx_ff + 1'b1;
         OP_ADD_RD: cnt_addr = bkt_ff;
         OP_SUM:    cnt_addr = idx_ff + 1'b1;
         OP_TGT: begin
            mul_a = count_ff;
            mul_b = pm_ff;
         end
         OP_PW_MUL: begin
            mul_a = s_ff;
            mul_b = PCT_SCALE;
         end
         OP_PL_RD:  bnd_addr = (idx_ff == '0) ? '0 : idx_ff - 1'b1;
         OP_PM_SC: begin
            mul_a = s_ff - c_ff;
            mul_b = PCT_SCALE;
         end
         OP_PNUM: begin
            mul_a = c_ff;
            mul_b = PCT_SCALE;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      div_start = ((op == OP_AVG_GO) && (count_ff != '0)) || (op == OP_PDIV_GO);
      if (op == OP_AVG_GO) begin
         div_d   = sum_ff;
         div_num = PROD_W'(1);
         div_den = PROD_W'(count_ff);
      end else begin
         div_d   = right_ge ? right_ff - left_ff : left_ff - right_ff;
         div_num = num_ff;
         div_den = den_ff;
      end
   end

   bhp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start),
      .d       (div_d),
      .num     (div_num),
      .den     (div_den),
      .done    (div_done),
      .quot    (div_q),
      .inexact (div_inexact)
   );

   always_ff @(posedge clock) begin
      bnd_rd_ff <= bnd_mem[bnd_addr];
      cnt_rd_ff <= cnt_valid_ff[cnt_addr] ? cnt_mem[cnt_addr] : '0;
      if ((op == OP_LOAD) && (req_data.command == CMD_WRITE)
          && (32'(req_data.bucket_index) < NBUCKETS)) begin
         bnd_mem[IDX_W'(req_data.bucket_index)] <= req_data.sample_value;
      end
      if (op == OP_ADD_WR) begin
         cnt_mem[bkt_ff] <= cnt_rd_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= '0;
         sum_ff       <= '0;
         max_ff       <= '0;
      end else if (op == OP_LOAD) begin
         if (req_data.command == CMD_ADD) begin
            sum_ff <= sum_ff + req_data.sample_value;
            if (req_data.sample_value > max_ff) begin
               max_ff <= req_data.sample_value;
            end
         end else if (req_data.command == CMD_CLEAR) begin
            cnt_valid_ff <= '0;
            sum_ff       <= '0;
            max_ff       <= '0;
         end
      end else if (op == OP_ADD_WR) begin
         cnt_valid_ff[bkt_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(mul_a) * PROD_W'(mul_b);
      unique case (op)
         OP_LOAD: begin
            key_ff <= (req_data.command == CMD_ADD) ? req_data.sample_value : max_ff;
            pm_ff  <= req_data.percentile_milli;
            idx_ff <= '0;
         end
         OP_FIND: begin
            if (find_hit) begin
               bkt_ff <= idx_ff;
               idx_ff <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         OP_SUM_RD: count_ff <= '0;
         OP_SUM: begin
            count_ff <= count_ff + cnt_rd_ff;
            if (idx_ff != bkt_ff) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         OP_AVG_GO: avg_ff <= '0;
         OP_AVG_WAIT: begin
            if (div_done) begin
               avg_ff <= div_q;
            end
         end
         OP_TGT: begin
            idx_ff <= '0;
            s_ff   <= '0;
         end
         OP_TGT_LD: target_ff <= prod_ff;
         OP_PW_ACC: begin
            c_ff <= cnt_rd_ff;
            s_ff <= s_ff + cnt_rd_ff;
         end
         OP_PW_CMP: begin
            if (prod_ff < target_ff) begin
               idx_ff <= idx_ff + 1'b1;
            end
         end
         OP_PMAX:  pct_ff <= max_ff;
         OP_PR_RD: left_ff <= bnd_rd_ff;
         OP_PM_SC: right_ff <= bnd_rd_ff;
         OP_PNUM:  num_ff <= target_ff - prod_ff;
         OP_PDEN: begin
            den_ff <= prod_ff;
            if (num_ff >= prod_ff) begin
               num_ff <= prod_ff;
            end
         end
         OP_PFIN:  pct_ff <= (interp > max_ff) ? max_ff : interp;
         OP_OUT: begin
            rsp_ff.event_count      <= count_ff;
            rsp_ff.average_value    <= avg_ff;
            rsp_ff.max_value        <= max_ff;
            rsp_ff.percentile_value <= pct_ff;
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      status.find_hit   = find_hit;
      status.sum_last   = (idx_ff == bkt_ff);
      status.count_zero = (count_ff == '0);
      status.bkt_zero   = (bkt_ff == '0);
      status.pct_hit    = (prod_ff >= target_ff);
      status.pct_last   = (idx_ff == bkt_ff - 1'b1);
      status.c_zero     = (c_ff == '0);
      status.div_done   = div_done;
   end

endmodule

// ===== sv/bhp_ctrl.sv =====
// Controller of the histogram: sequences adds, queries, bound writes, clears
// and the result handshake. Depends on bhp_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "bucketed_histogram_percentile_macros.svh"
module bhp_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_command,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  bhp_pkg::dp_status_type     status,
   output logic [bhp_pkg::OP_W-1:0]   op
);
   import bhp_pkg::*;

   localparam logic [4:0] S_IDLE      = 5'd0;
   localparam logic [4:0] S_FIND_RD   = 5'd1;
   localparam logic [4:0] S_FIND      = 5'd2;
   localparam logic [4:0] S_ADD_RD    = 5'd3;
   localparam logic [4:0] S_ADD_WR    = 5'd4;
   localparam logic [4:0] S_SUM_RD    = 5'd5;
   localparam logic [4:0] S_SUM       = 5'd6;
   localparam logic [4:0] S_AVG_GO    = 5'd7;
   localparam logic [4:0] S_AVG_WAIT  = 5'd8;
   localparam logic [4:0] S_TGT       = 5'd9;
   localparam logic [4:0] S_TGT_LD    = 5'd10;
   localparam logic [4:0] S_PW_RD     = 5'd11;
   localparam logic [4:0] S_PW_ACC    = 5'd12;
   localparam logic [4:0] S_PW_MUL    = 5'd13;
   localparam logic [4:0] S_PW_CMP    = 5'd14;
   localparam logic [4:0] S_PMAX      = 5'd15;
   localparam logic [4:0] S_PL_RD     = 5'd16;
   localparam logic [4:0] S_PR_RD     = 5'd17;
   localparam logic [4:0] S_PM_SC     = 5'd18;
   localparam logic [4:0] S_PNUM      = 5'd19;
   localparam logic [4:0] S_PDEN      = 5'd20;
   localparam logic [4:0] S_PDIV_GO   = 5'd21;
   localparam logic [4:0] S_PDIV_WAIT = 5'd22;
   localparam logic [4:0] S_PFIN      = 5'd23;
   localparam logic [4:0] S_OUT       = 5'd24;

   logic [4:0] state_ff;
   logic [4:0] state_in;
   logic       is_query_ff;
   logic       is_query_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       accept;
   logic       out_load;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_load  = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in    = state_ff;
      is_query_in = is_query_ff;
      op          = OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op          = OP_LOAD;
               is_query_in = (req_command == CMD_QUERY);
               if ((req_command == CMD_ADD) || (req_command == CMD_QUERY)) begin
                  state_in = S_FIND_RD;
               end
            end
         end
         S_FIND_RD: begin
            op       = OP_FIND_RD;
            state_in = S_FIND;
         end
         S_FIND: begin
            op = OP_FIND;
            if (status.find_hit) begin
               state_in = is_query_ff ? S_SUM_RD : S_ADD_RD;
            end
         end
         S_ADD_RD: begin
            op       = OP_ADD_RD;
            state_in = S_ADD_WR;
         end
         S_ADD_WR: begin
            op       = OP_ADD_WR;
            state_in = S_IDLE;
         end
         S_SUM_RD: begin
            op       = OP_SUM_RD;
            state_in = S_SUM;
         end
         S_SUM: begin
            op = OP_SUM;
            if (status.sum_last) begin
               state_in = S_AVG_GO;
            end
         end
         S_AVG_GO: begin
            op       = OP_AVG_GO;
            state_in = status.count_zero ? S_TGT : S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            op = OP_AVG_WAIT;
            if (status.div_done) begin
               state_in = S_TGT;
            end
         end
         S_TGT: begin
            op       = OP_TGT;
            state_in = status.bkt_zero ? S_PMAX : S_TGT_LD;
         end
         S_TGT_LD: begin
            op       = OP_TGT_LD;
            state_in = S_PW_RD;
         end
         S_PW_RD: begin
            op       = OP_PW_RD;
            state_in = S_PW_ACC;
         end
         S_PW_ACC: begin
            op       = OP_PW_ACC;
            state_in = S_PW_MUL;
         end
         S_PW_MUL: begin
            op       = OP_PW_MUL;
            state_in = S_PW_CMP;
         end
         S_PW_CMP: begin
            op = OP_PW_CMP;
            priority if (status.pct_hit) begin
               state_in = S_PL_RD;
            end else if (status.pct_last) begin
               state_in = S_PMAX;
            end else begin
               state_in = S_PW_RD;
            end
         end
         S_PMAX: begin
            op       = OP_PMAX;
            state_in = S_OUT;
         end
         S_PL_RD: begin
            op       = OP_PL_RD;
            state_in = S_PR_RD;
         end
         S_PR_RD: begin
            op       = OP_PR_RD;
            state_in = S_PM_SC;
         end
         S_PM_SC: begin
            op       = OP_PM_SC;
            state_in = S_PNUM;
         end
         S_PNUM: begin
            op       = OP_PNUM;
            state_in = S_PDEN;
         end
         S_PDEN: begin
            op       = OP_PDEN;
            state_in = status.c_zero ? S_PFIN : S_PDIV_GO;
         end
         S_PDIV_GO: begin
            op       = OP_PDIV_GO;
            state_in = S_PDIV_WAIT;
         end
         S_PDIV_WAIT: begin
            if (status.div_done) begin
               state_in = S_PFIN;
            end
         end
         S_PFIN: begin
            op       = OP_PFIN;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_load) begin
               op       = OP_OUT;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         is_query_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_query_ff  <= is_query_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `BHP_ASSERT_IMP(a_div_done_in_wait, clock, reset, status.div_done, (state_ff == S_AVG_WAIT) || (state_ff == S_PDIV_WAIT), "Divider finished outside a wait state")
   `BHP_ASSERT_NXT(a_short_cmd_idle, clock, reset, accept && ((req_command == CMD_WRITE) || (req_command == CMD_CLEAR)), state_ff == S_IDLE, "Write or clear request left the idle state")
   `BHP_ASSERT_NXT(a_out_sets_valid, clock, reset, out_load, rsp_valid_ff && (state_ff == S_IDLE), "Result load did not raise the response valid")

endmodule

// ===== sv/bucketed_histogram_percentile.sv =====
// Top level of the bucketed histogram with percentile query.
// Depends on bhp_pkg, bhp_ctrl and bhp_dp.
//
// Requests arrive on req_valid/req_ready/req_data; each carries a command.
// An add, write bound or clear produces no response; a query produces one
// response on rsp_valid/rsp_ready/rsp_data with count, average, maximum and
// percentile. One request is in work at a time; req_ready is high only when
// the block is idle.
// Write bound and clear leave the block idle. An add first runs the bound
// search (one bound per cycle) to find its bucket b, then counts into b.
// A query runs the bound search, a count sweep over buckets 0..b, a
// bit-serial division for the average, a walk over the buckets below b,
// and a second division for the interpolation. The shared divider sets
// most of the query time.
// The response sits in an output register; a new request is taken while it
// waits, and a later query holds in its last step until the slot frees.
// Reset clears counters, sum, maximum and the handshake; bounds must be
// written before they are used.
`timescale 1ns / 1ps
module bucketed_histogram_percentile (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  bhp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output bhp_pkg::rsp_type rsp_data
);
   import bhp_pkg::*;

   logic [OP_W-1:0] op;
   dp_status_type   status;

   bhp_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_data.command),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .op          (op)
   );

   bhp_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .status   (status)
   );

endmodule
